// ===== rtl/yhd_pkg.sv =====
// Shared types, constants and tables of the YOLO head decoder.
package yhd_pkg;

    localparam int GRID_MAX_DEF  = 256;
    localparam int CLASS_MAX_DEF = 255;
    localparam int ANCHOR_COUNT  = 3;
    // The grid position field carries column or row counts for any grid of up to 2048 cells per side.
    localparam int CELL_W        = 11;
    localparam int TAYLOR_TERMS  = 12;

    localparam logic [17:0] LOG2E_Q16 = 18'd94548;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_CLASS_COUNT = 3'd2,
        REG_DECODE_MODE = 3'd3,
        REG_STRIDE      = 3'd4,
        REG_ANCHOR_0    = 3'd5,
        REG_ANCHOR_1    = 3'd6,
        REG_ANCHOR_2    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_V3   = 2'd1,
        MODE_V5   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_X     = 3'd0,
        KIND_Y     = 3'd1,
        KIND_W     = 3'd2,
        KIND_H     = 3'd3,
        KIND_SCORE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OP_PASS  = 3'd0,
        OP_SCORE = 3'd1,
        OP_XY3   = 3'd2,
        OP_XY5   = 3'd3,
        OP_WH3   = 3'd4,
        OP_WH5   = 3'd5
    } op_t;

    typedef struct packed {
        logic [8:0]                    grid_width;
        logic [8:0]                    grid_height;
        logic [7:0]                    class_count;
        logic [1:0]                    decode_mode;
        logic [15:0]                   stride;
        logic [ANCHOR_COUNT-1:0][31:0] anchor_pair;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] logit;
        kind_t              kind;
        op_t                op;
        logic [CELL_W-1:0]  cell_pos;
        logic [15:0]        anchor;
        logic               last;
    } entry_t;

    // floor((2^32 - 1) / k) for the Taylor term division.
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                4'd1:    r = 32'd4294967295;
                4'd2:    r = 32'd2147483647;
                4'd3:    r = 32'd1431655765;
                4'd4:    r = 32'd1073741823;
                4'd5:    r = 32'd858993459;
                4'd6:    r = 32'd715827882;
                4'd7:    r = 32'd613566756;
                4'd8:    r = 32'd536870911;
                4'd9:    r = 32'd477218588;
                4'd10:   r = 32'd429496729;
                4'd11:   r = 32'd390451572;
                4'd12:   r = 32'd357913941;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/yhd_fifo.sv =====
// Two-entry queue between the classifying front end and the arithmetic back end.
module yhd_fifo
    import yhd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output entry_t q_entry
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/yhd_front.sv =====
// Front end: accepts logits, tracks the stream position and classifies each value.
module yhd_front
    import yhd_pkg::*;
#(
    parameter int GRID_MAX  = GRID_MAX_DEF,
    parameter int CLASS_MAX = CLASS_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] logit,
    input  logic               frame_start,
    input  logic               fifo_full,
    output logic               push,
    output entry_t             push_entry
);

    localparam int CW  = $clog2(GRID_MAX + 1);
    localparam int CHW = $clog2(CLASS_MAX + 6);
    localparam int AW  = $clog2(ANCHOR_COUNT);

    logic [CW-1:0]  col_reg, row_reg, col_next, row_next;
    logic [CHW-1:0] chan_reg, chan_next;
    logic [AW-1:0]  anc_reg, anc_next;

    logic [CW-1:0]  bound_w, bound_h, cur_col, cur_row;
    logic [CHW-1:0] chans, cur_chan;
    logic [AW-1:0]  cur_anc, anc_sel;
    logic [CW:0]    col_inc, row_inc;
    logic [CHW:0]   chan_inc;
    logic [AW:0]    anc_inc;
    logic [31:0]    pair;
    kind_t          kind;
    op_t            op;

    function automatic logic [CW-1:0] clamp_grid(input logic [8:0] v);
        begin
            if (v == 9'd0)
                return CW'(1);
            else if (32'(v) > GRID_MAX)
                return CW'(GRID_MAX);
            else
                return CW'(v);
        end
    endfunction

    function automatic logic [CHW-1:0] clamp_class(input logic [7:0] v);
        begin
            if (v == 8'd0)
                return CHW'(1);
            else if (32'(v) > CLASS_MAX)
                return CHW'(CLASS_MAX);
            else
                return CHW'(v);
        end
    endfunction

    assign in_ready = !fifo_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        bound_w  = clamp_grid(cfg.grid_width);
        bound_h  = clamp_grid(cfg.grid_height);
        chans    = CHW'(5) + clamp_class(cfg.class_count);

        cur_col  = frame_start ? '0 : col_reg;
        cur_row  = frame_start ? '0 : row_reg;
        cur_chan = frame_start ? '0 : chan_reg;
        cur_anc  = frame_start ? '0 : anc_reg;

        anc_sel  = (32'(cur_anc) < ANCHOR_COUNT) ? cur_anc : AW'(ANCHOR_COUNT - 1);
        kind     = (cur_chan < CHW'(4)) ? kind_t'(cur_chan[2:0]) : KIND_SCORE;
        pair     = cfg.anchor_pair[anc_sel];

        unique case (kind)
            KIND_X, KIND_Y:
            begin
                priority case (cfg.decode_mode)
                    MODE_V3: op = OP_XY3;
                    MODE_V5: op = OP_XY5;
                    default: op = OP_PASS;
                endcase
            end
            KIND_W, KIND_H:
            begin
                priority case (cfg.decode_mode)
                    MODE_V3: op = OP_WH3;
                    MODE_V5: op = OP_WH5;
                    default: op = OP_PASS;
                endcase
            end
            default:
            begin
                op = ((cfg.decode_mode == MODE_V3) || (cfg.decode_mode == MODE_V5))
                     ? OP_SCORE : OP_PASS;
            end
        endcase

        push_entry.logit    = logit;
        push_entry.kind     = kind;
        push_entry.op       = op;
        push_entry.cell_pos = (kind == KIND_Y) ? CELL_W'(cur_row) : CELL_W'(cur_col);
        push_entry.anchor   = (kind == KIND_W) ? pair[31:16] : pair[15:0];
        push_entry.last     = (32'(cur_anc) == ANCHOR_COUNT - 1) &&
                              (cur_chan == chans - CHW'(1)) &&
                              (cur_row == bound_h - CW'(1)) &&
                              (cur_col == bound_w - CW'(1));

        // Column is innermost; a counter past a shrunken bound wraps at the next advance.
        col_inc  = {1'b0, cur_col} + (CW+1)'(1);
        row_inc  = {1'b0, cur_row} + (CW+1)'(1);
        chan_inc = {1'b0, cur_chan} + (CHW+1)'(1);
        anc_inc  = {1'b0, cur_anc} + (AW+1)'(1);
        col_next  = cur_col;
        row_next  = cur_row;
        chan_next = cur_chan;
        anc_next  = cur_anc;
        if (col_inc >= {1'b0, bound_w})
        begin
            col_next = '0;
            if (row_inc >= {1'b0, bound_h})
            begin
                row_next = '0;
                if (chan_inc >= {1'b0, chans})
                begin
                    chan_next = '0;
                    anc_next  = (32'(anc_inc) >= ANCHOR_COUNT) ? '0 : anc_inc[AW-1:0];
                end
                else
                begin
                    chan_next = chan_inc[CHW-1:0];
                end
            end
            else
            begin
                row_next = row_inc[CW-1:0];
            end
        end
        else
        begin
            col_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
            anc_reg  <= '0;
        end
        else if (push)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
            anc_reg  <= anc_next;
        end
    end

endmodule

// ===== rtl/yhd_back.sv =====
// Back end: sequenced fixed-point exp, sigmoid and box arithmetic on a shared multiplier.
module yhd_back
    import yhd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        stride,
    input  logic               q_valid,
    input  entry_t             q_entry,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] decoded_value,
    output logic [2:0]         value_kind,
    output logic               image_end
);

    localparam int A_W = CELL_W + 18;
    localparam logic signed [A_W-1:0] HALF_Q16 = A_W'(32768);
    localparam logic [31:0] SAT_MAX = 32'h7fffffff;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b000000000001,
        ST_EXP_T     = 12'b000000000010,
        ST_EXP_G     = 12'b000000000100,
        ST_G_LATCH   = 12'b000000001000,
        ST_TERM_MUL  = 12'b000000010000,
        ST_TERM_REC  = 12'b000000100000,
        ST_TERM_FIX  = 12'b000001000000,
        ST_SIG_SETUP = 12'b000010000000,
        ST_SIG_DIV   = 12'b000100000000,
        ST_POST      = 12'b001000000000,
        ST_WH5_B     = 12'b010000000000,
        ST_FINISH    = 12'b100000000000
    } state_t;

    state_t             state_reg, state_next;
    entry_t             ent_reg;
    logic signed [67:0] prod_reg;
    logic signed [8:0]  n_reg;
    logic [29:0]        g_reg;
    logic [30:0]        term_reg, sum_reg;
    logic [3:0]         k_reg;
    logic [29:0]        xq_reg;
    logic [56:0]        rem_reg;
    logic [71:0]        den_reg;
    logic [16:0]        q_reg, s_reg;
    logic [4:0]         bit_reg;
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic [2:0]         kind_reg;
    logic               last_reg;

    logic signed [33:0]    mul_a, mul_b;
    logic signed [67:0]    mul_p;
    logic                  mul_en, load_out;
    logic signed [17:0]    x_ext, exp_arg;
    logic [29:0]           q0;
    logic [33:0]           qk, rmd;
    logic [30:0]           q_fix;
    logic [8:0]            n_mag;
    logic [55:0]           d_val;
    logic                  div_ge;
    logic [56:0]           rem_sub;
    logic [16:0]           q_new;
    logic signed [A_W-1:0] cell_term, s_term, a_val;
    logic signed [9:0]     sh_wh;
    logic [9:0]            k_wh;
    logic [62:0]           wide_wh;
    logic [47:0]           rnd_wh, val_wh;
    logic signed [45:0]    xy_bias;
    logic [50:0]           wh5_sum;
    logic [17:0]           score_sum;
    logic signed [31:0]    res;

    assign mul_p         = mul_a * mul_b;
    assign out_valid     = out_valid_reg;
    assign decoded_value = value_reg;
    assign value_kind    = kind_reg;
    assign image_end     = last_reg;

    always_comb
    begin
        x_ext   = {{2{ent_reg.logit[15]}}, ent_reg.logit};
        exp_arg = (ent_reg.op == OP_WH3) ? x_ext : -x_ext;

        // Division by k: reciprocal estimate is low by at most one.
        q0    = prod_reg[61:32];
        qk    = {4'd0, q0} * {30'd0, k_reg};
        rmd   = {4'd0, xq_reg} - qk;
        q_fix = (rmd >= {30'd0, k_reg}) ? ({1'b0, q0} + 31'd1) : {1'b0, q0};

        n_mag = 9'(-n_reg);
        if (!n_reg[8])
            d_val = (56'd1 << 30) + ({25'd0, sum_reg} << n_reg[4:0]);
        else
            d_val = (56'd1 << 30) +
                    ((n_mag >= 9'd31) ? 56'd0 : ({25'd0, sum_reg} >> n_mag[4:0]));

        div_ge  = ({15'd0, rem_reg} >= den_reg);
        rem_sub = rem_reg - den_reg[56:0];
        q_new   = {q_reg[15:0], div_ge};

        cell_term = $signed({2'b00, ent_reg.cell_pos, 16'd0});
        s_term    = $signed({{(A_W-17){1'b0}}, s_reg});
        a_val     = (ent_reg.op == OP_XY5) ? (s_term + s_term - HALF_Q16 + cell_term)
                                           : (s_term + cell_term);

        sh_wh   = 10'(n_reg) - 10'sd26;
        k_wh    = 10'(-sh_wh);
        wide_wh = 63'(prod_reg[46:0]) << sh_wh[4:0];
        rnd_wh  = 48'(prod_reg[46:0]) + (48'd1 << (k_wh[5:0] - 6'd1));
        val_wh  = rnd_wh >> k_wh[5:0];

        xy_bias   = $signed(prod_reg[45:0]) + 46'sd32768;
        wh5_sum   = {prod_reg[48:0], 2'b00} + 51'd134217728;
        score_sum = {1'b0, s_reg} + 18'd128;

        unique case (ent_reg.op)
            OP_PASS:  res = {{16{ent_reg.logit[15]}}, ent_reg.logit};
            OP_SCORE: res = {23'd0, score_sum[16:8]};
            OP_XY3, OP_XY5: res = 32'(xy_bias >>> 16);
            OP_WH5:   res = {9'd0, wh5_sum[50:28]};
            OP_WH3:
            begin
                priority if (prod_reg[46:0] == 47'd0)
                    res = 32'sd0;
                else if (sh_wh > 10'sd16)
                    res = SAT_MAX;
                else if (!sh_wh[9])
                    res = (wide_wh > 63'(SAT_MAX)) ? SAT_MAX : wide_wh[31:0];
                else if (k_wh >= 10'd48)
                    res = 32'sd0;
                else
                    res = (val_wh > 48'(SAT_MAX)) ? SAT_MAX : val_wh[31:0];
            end
            default:  res = 32'sd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        mul_en     = 1'b0;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = (q_entry.op == OP_PASS) ? ST_FINISH : ST_EXP_T;
                end
            end
            ST_EXP_T:
            begin
                mul_a      = {{16{exp_arg[17]}}, exp_arg};
                mul_b      = {16'd0, LOG2E_Q16};
                mul_en     = 1'b1;
                state_next = ST_EXP_G;
            end
            ST_EXP_G:
            begin
                mul_a      = {10'd0, prod_reg[23:0]};
                mul_b      = {4'd0, LN2_Q30};
                mul_en     = 1'b1;
                state_next = ST_G_LATCH;
            end
            ST_G_LATCH:
            begin
                state_next = ST_TERM_MUL;
            end
            ST_TERM_MUL:
            begin
                mul_a      = {3'd0, term_reg};
                mul_b      = {4'd0, g_reg};
                mul_en     = 1'b1;
                state_next = ST_TERM_REC;
            end
            ST_TERM_REC:
            begin
                mul_a      = {4'd0, prod_reg[59:30]};
                mul_b      = {2'd0, recip_k(k_reg)};
                mul_en     = 1'b1;
                state_next = ST_TERM_FIX;
            end
            ST_TERM_FIX:
            begin
                if (k_reg == 4'(TAYLOR_TERMS))
                    state_next = (ent_reg.op == OP_WH3) ? ST_POST : ST_SIG_SETUP;
                else
                    state_next = ST_TERM_MUL;
            end
            ST_SIG_SETUP:
            begin
                state_next = (n_reg > 9'sd24) ? ST_POST : ST_SIG_DIV;
            end
            ST_SIG_DIV:
            begin
                if (bit_reg == 5'd0)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                priority case (ent_reg.op)
                    OP_XY3, OP_XY5:
                    begin
                        mul_a      = {{(34-A_W){a_val[A_W-1]}}, a_val};
                        mul_b      = {18'd0, stride};
                        mul_en     = 1'b1;
                        state_next = ST_FINISH;
                    end
                    OP_WH5:
                    begin
                        mul_a      = {17'd0, s_reg};
                        mul_b      = {17'd0, s_reg};
                        mul_en     = 1'b1;
                        state_next = ST_WH5_B;
                    end
                    OP_WH3:
                    begin
                        mul_a      = {18'd0, ent_reg.anchor};
                        mul_b      = {3'd0, sum_reg};
                        mul_en     = 1'b1;
                        state_next = ST_FINISH;
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_WH5_B:
            begin
                mul_a      = {18'd0, ent_reg.anchor};
                mul_b      = {1'b0, prod_reg[32:0]};
                mul_en     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= 4'd0;
            bit_reg       <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_G_LATCH)
                k_reg <= 4'd1;
            else if (state_reg == ST_TERM_FIX)
                k_reg <= k_reg + 4'd1;
            if (state_reg == ST_SIG_SETUP)
                bit_reg <= 5'd16;
            else if (state_reg == ST_SIG_DIV)
                bit_reg <= bit_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        if (q_pop)
            ent_reg <= q_entry;
        if (load_out)
        begin
            value_reg <= res;
            kind_reg  <= ent_reg.kind;
            last_reg  <= ent_reg.last;
        end
        unique case (state_reg)
            ST_EXP_G:
            begin
                n_reg <= prod_reg[32:24];
            end
            ST_G_LATCH:
            begin
                g_reg    <= prod_reg[53:24];
                term_reg <= 31'd1 << 30;
                sum_reg  <= 31'd1 << 30;
            end
            ST_TERM_REC:
            begin
                xq_reg <= prod_reg[59:30];
            end
            ST_TERM_FIX:
            begin
                term_reg <= q_fix;
                sum_reg  <= sum_reg + q_fix;
            end
            ST_SIG_SETUP:
            begin
                rem_reg <= (57'd1 << 46) + {2'd0, d_val[55:1]};
                den_reg <= {d_val, 16'd0};
                q_reg   <= 17'd0;
                if (n_reg > 9'sd24)
                    s_reg <= 17'd0;
            end
            ST_SIG_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_sub;
                den_reg <= den_reg >> 1;
                q_reg   <= q_new;
                if (bit_reg == 5'd0)
                    s_reg <= q_new;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/yolo_head_decode.sv =====
// A passthrough value goes from the queue straight to the output register. A v3/v4 width
// or height runs the exp series; an x, y or score value runs the exp series and then the
// sigmoid divider, and a v5 width or height adds an anchor multiply after those. The exp
// series has 12 terms, each a multiply, a reciprocal multiply and a fix-up step. The back
// end takes one value at a time; the two-entry queue lets input transactions land while
// it is busy. Reset (rst_n low, asynchronous) clears counters, queue and result handshake and loads the defaults.
module yolo_head_decode
    import yhd_pkg::*;
#(
    parameter int GRID_MAX  = GRID_MAX_DEF,
    parameter int CLASS_MAX = CLASS_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] logit,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] decoded_value,
    output logic [2:0]         value_kind,
    output logic               image_end,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers. The user must write them only while the decoder is idle;
    // the block itself does not enforce this. Both ends read them directly.
    cfg_t cfg_reg;

    // Handshake between the front end, the queue and the back end.
    logic   push;
    logic   fifo_full;
    entry_t push_entry;
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= 9'd13;
            cfg_reg.grid_height <= 9'd13;
            cfg_reg.class_count <= 8'd80;
            cfg_reg.decode_mode <= MODE_V3;
            cfg_reg.stride      <= 16'd2048;
            cfg_reg.anchor_pair <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GRID_WIDTH:  cfg_reg.grid_width     <= cfg_data[8:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height    <= cfg_data[8:0];
                REG_CLASS_COUNT: cfg_reg.class_count    <= cfg_data[7:0];
                REG_DECODE_MODE: cfg_reg.decode_mode    <= cfg_data[1:0];
                REG_STRIDE:      cfg_reg.stride         <= cfg_data[15:0];
                REG_ANCHOR_0:    cfg_reg.anchor_pair[0] <= cfg_data;
                REG_ANCHOR_1:    cfg_reg.anchor_pair[1] <= cfg_data;
                REG_ANCHOR_2:    cfg_reg.anchor_pair[2] <= cfg_data;
            endcase
        end
    end

    // The front end tags each value with its channel kind, grid position, anchor size
    // and end-of-image flag, so the back end never looks at stream position.
    yhd_front #(
        .GRID_MAX  (GRID_MAX),
        .CLASS_MAX (CLASS_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .logit       (logit),
        .frame_start (frame_start),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    yhd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // The back end owns the output register; it finishes the next value while the
    // previous result waits only if that result is taken in the same cycle.
    yhd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .stride        (cfg_reg.stride),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .decoded_value (decoded_value),
        .value_kind    (value_kind),
        .image_end     (image_end)
    );

endmodule

// ===== rtl/yhd_checker.sv =====
// Port-level assertions for the YOLO head decoder and their bind to the top level.
module yhd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] decoded_value,
    input logic [2:0]         value_kind,
    input logic               image_end
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decoded_value) &&
                                    $stable(value_kind) && $stable(image_end))
        else $error("result changed while stalled");

    // The kind code is always one of the five channel kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> value_kind <= 3'd4)
        else $error("value kind out of range");

    // The last value of an image is always a class score.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> value_kind == 3'd4)
        else $error("image end on a box channel");

    // No result can be pending right after reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind yolo_head_decode yhd_checker u_yhd_checker (.*);
